### sv/sisi_pkg.sv
package sisi_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;

    // per-cell control, driven from the top level
    typedef struct packed {
        logic occupied;   // cell position below the entry count
        logic shift_en;   // an insert is being committed this cycle
        logic rd_sel;     // cell position matches the read index
    } cell_ctl_t;

endpackage

### sv/sisi_cell.sv
module sisi_cell
    import sisi_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  word_t     value,
    input  word_t     prev_entry,
    input  logic      prev_above,
    output word_t     entry,
    output logic      above,
    output logic      match,
    output word_t     rd_data
);

    word_t entry_reg;
    word_t entry_next;

    // value sorts before this cell (an empty cell always counts as above)
    assign above   = !ctl.occupied || (value < entry_reg);
    assign match   = ctl.occupied && (value == entry_reg);
    assign rd_data = ctl.rd_sel ? entry_reg : '0;
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_en)
        begin
            if (prev_above)
            begin
                entry_next = prev_entry;
            end
            else if (above)
            begin
                entry_next = value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### sv/sorted_int_set_insert_lookup.sv
// Sorted set of up to 16 distinct signed 32-bit integers, held in ascending order in a row of
// compare-and-shift cells. A beat is taken when start is high and busy is low; busy then stays
// high while every cell compares the value in parallel, and the result appears on the output
// ports the following cycle with done high for exactly that one cycle. Each beat passes a
// registered command stage ahead of the cell row; no new beat is taken while busy is high, and
// a new beat may be started in the same cycle that done is shown. An add of a new value
// shifts every larger entry up one cell and drops the value into the freed slot; an add to a
// full set is refused with rejected_full. Results cannot be held off: sample them when done
// is high. No clearing pass is needed after reset.
module sorted_int_set_insert_lookup
    import sisi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic signed [31:0] value,
    input  logic [3:0]         index,
    output logic               done,
    output logic               present,
    output logic               inserted,
    output logic               rejected_full,
    output logic [4:0]         count,
    output logic signed [31:0] read_data,
    output logic               read_ok
);

    logic             busy_reg;
    logic [1:0]       func_reg;
    word_t            value_reg;
    logic [3:0]       index_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             done_reg;
    logic             present_reg;
    logic             present_next;
    logic             inserted_reg;
    logic             inserted_next;
    logic             rejected_reg;
    logic             rejected_next;
    word_t            rdata_reg;
    word_t            rdata_next;
    logic             rok_reg;
    logic             rok_next;

    cell_ctl_t        ctl      [CAPACITY];
    word_t            entry_w  [CAPACITY];
    logic             above_w  [CAPACITY];
    word_t            rd_w     [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic             do_insert;
    logic             held;
    logic             idx_ok;
    word_t            rd_any;

    assign held   = |match_vec;
    assign idx_ok = (32'(index_reg) < 32'(count_reg));

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_any = rd_any | rd_w[i];
        end
    end

    assign do_insert = busy_reg && (func_reg == FUNC_ADD) && !held
                       && (32'(count_reg) < CAPACITY);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign ctl[g].occupied = (32'(count_reg) > g);
            assign ctl[g].shift_en = do_insert;
            assign ctl[g].rd_sel   = (32'(index_reg) == g);

            if (g == 0)
            begin : g_head
                sisi_cell u_cell (
                    .clk        (clk),
                    .ctl        (ctl[g]),
                    .value      (value_reg),
                    .prev_entry ('0),
                    .prev_above (1'b0),
                    .entry      (entry_w[g]),
                    .above      (above_w[g]),
                    .match      (match_vec[g]),
                    .rd_data    (rd_w[g])
                );
            end
            else
            begin : g_body
                sisi_cell u_cell (
                    .clk        (clk),
                    .ctl        (ctl[g]),
                    .value      (value_reg),
                    .prev_entry (entry_w[g-1]),
                    .prev_above (above_w[g-1]),
                    .entry      (entry_w[g]),
                    .above      (above_w[g]),
                    .match      (match_vec[g]),
                    .rd_data    (rd_w[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        present_next  = 1'b0;
        inserted_next = 1'b0;
        rejected_next = 1'b0;
        rdata_next    = '0;
        rok_next      = 1'b0;
        case (func_reg)
            FUNC_ADD:
            begin
                present_next  = held;
                inserted_next = do_insert;
                rejected_next = !held && !do_insert;
                if (do_insert)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                present_next = held;
            end
            FUNC_READ:
            begin
                rok_next   = idx_ok;
                rdata_next = idx_ok ? rd_any : '0;
            end
            default:
            begin
            end
        endcase
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            func_reg  <= func;
            value_reg <= value;
            index_reg <= index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                busy_reg  <= 1'b0;
                count_reg <= count_next;
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            present_reg  <= present_next;
            inserted_reg <= inserted_next;
            rejected_reg <= rejected_next;
            rdata_reg    <= rdata_next;
            rok_reg      <= rok_next;
        end
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign present       = present_reg;
    assign inserted      = inserted_reg;
    assign rejected_full = rejected_reg;
    assign count         = 5'(count_reg);
    assign read_data     = rdata_reg;
    assign read_ok       = rok_reg;

endmodule

### test/sorted_int_set_insert_lookup_checker.sv
`timescale 1ns / 100ps

module sorted_int_set_insert_lookup_checker
    import sisi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  func,
    input  word_t       value,
    input  logic [3:0]  index,
    input  logic        done,
    input  logic        present,
    input  logic        inserted,
    input  logic        rejected_full,
    input  logic [4:0]  count,
    input  word_t       read_data,
    input  logic        read_ok,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic       present;
        logic       inserted;
        logic       rejected_full;
        logic [4:0] count;
        word_t      read_data;
        logic       read_ok;
    } set_outcome_t;

    word_t        shadow_words [CAPACITY];
    int           shadow_count;
    set_outcome_t outcome_q [$];

    // updates the shadow set and returns what the block should report
    function automatic set_outcome_t apply_op(input logic [1:0] f, input word_t v,
                                              input logic [3:0] idx);
        set_outcome_t o;
        logic         held;
        int           i;
        int           pos;
        o    = '0;
        held = 1'b0;
        for (i = 0; i < shadow_count; i++)
        begin
            if (shadow_words[i] == v)
                held = 1'b1;
        end
        if (f == FUNC_ADD)
        begin
            if (held)
                o.present = 1'b1;
            else if (shadow_count >= CAPACITY)
                o.rejected_full = 1'b1;
            else
            begin
                // move larger entries up, then drop the value in
                pos = shadow_count;
                while (pos > 0 && v < shadow_words[pos-1])
                begin
                    shadow_words[pos] = shadow_words[pos-1];
                    pos--;
                end
                shadow_words[pos] = v;
                shadow_count++;
                o.inserted = 1'b1;
            end
        end
        else if (f == FUNC_QUERY)
            o.present = held;
        else if (f == FUNC_READ)
        begin
            if (int'(idx) < shadow_count)
            begin
                o.read_data = shadow_words[idx];
                o.read_ok   = 1'b1;
            end
        end
        o.count = 5'(shadow_count);
        return o;
    endfunction

    task automatic report(input string what, input set_outcome_t want,
                          input set_outcome_t seen);
        if (fail_count < 10)
            $display("%0t %s: want p=%0b i=%0b r=%0b c=%0d d=%0d ok=%0b, got p=%0b i=%0b r=%0b c=%0d d=%0d ok=%0b",
                     $realtime, what,
                     want.present, want.inserted, want.rejected_full, want.count,
                     want.read_data, want.read_ok,
                     seen.present, seen.inserted, seen.rejected_full, seen.count,
                     seen.read_data, seen.read_ok);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        set_outcome_t seen;
        set_outcome_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            outcome_q.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // the result shown now belongs to an earlier beat, so retire it first
            if (done)
            begin
                seen = {present, inserted, rejected_full, count, read_data, read_ok};
                if (outcome_q.size() == 0)
                begin
                    report("result with no beat outstanding", '0, seen);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (seen !== want)
                    begin
                        report("result differs", want, seen);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_op(func, value, index));
            outstanding <= outcome_q.size();
        end
    end

endmodule

### test/sorted_int_set_insert_lookup_test.sv
`timescale 1ns / 100ps

module sorted_int_set_insert_lookup_test;
    import sisi_pkg::*;

    localparam logic [1:0] FUNC_NOP    = 2'd3;
    localparam int         ITEMS       = 1500;
    localparam int         QUIET_LIMIT = 1000;
    localparam word_t      WORD_MIN    = 32'sh8000_0000;
    localparam word_t      WORD_MAX    = 32'sh7fff_ffff;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    word_t       value;
    logic [3:0]  index;
    logic        done;
    logic        present;
    logic        inserted;
    logic        rejected_full;
    logic [4:0]  count;
    word_t       read_data;
    logic        read_ok;
    int          fail_count;
    int          outstanding;

    int          idle_pct;
    int          beats_sent;
    int          quiet_cycles;
    word_t       used_values [$];

    sorted_int_set_insert_lookup i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .value         (value),
        .index         (index),
        .done          (done),
        .present       (present),
        .inserted      (inserted),
        .rejected_full (rejected_full),
        .count         (count),
        .read_data     (read_data),
        .read_ok       (read_ok)
    );

    sorted_int_set_insert_lookup_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .value         (value),
        .index         (index),
        .done          (done),
        .present       (present),
        .inserted      (inserted),
        .rejected_full (rejected_full),
        .count         (count),
        .read_data     (read_data),
        .read_ok       (read_ok),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // nothing accepted for too long means the block has hung
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // mix of values already seen, small ones, extremes and full-range words
    function automatic word_t pick_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40 && used_values.size() > 0)
            return used_values[$urandom_range(used_values.size() - 1)];
        else if (pick < 70)
            return $signed($urandom_range(40)) - 20;
        else if (pick < 80)
        begin
            case ($urandom_range(3))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic issue(input logic [1:0] f, input word_t v, input logic [3:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
            func  = 2'($urandom);
            value = $urandom;
            index = 4'($urandom);
            @(posedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        func  = f;
        value = v;
        index = idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (f != FUNC_NOP)
            beats_sent++;
        if (f == FUNC_ADD)
        begin
            used_values.push_back(v);
            if (used_values.size() > 64)
                void'(used_values.pop_front());
        end
    endtask

    initial
    begin : stimulus
        int    pick;
        bit    drained;
        start      = 1'b0;
        func       = FUNC_ADD;
        value      = '0;
        index      = '0;
        rst_n      = 1'b0;
        idle_pct   = 27;
        beats_sent = 0;
        drained    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty set, then inserts at the front, end and middle
        issue(FUNC_READ, 0, 4'd0);
        issue(FUNC_READ, 0, 4'd15);
        issue(FUNC_QUERY, 0, 4'd0);
        issue(FUNC_NOP, WORD_MAX, 4'd15);
        issue(FUNC_ADD, 100, 4'd0);
        issue(FUNC_ADD, -5, 4'd0);
        issue(FUNC_ADD, WORD_MAX, 4'd0);
        issue(FUNC_ADD, 7, 4'd0);
        issue(FUNC_ADD, WORD_MIN, 4'd0);
        issue(FUNC_ADD, 100, 4'd0);
        issue(FUNC_QUERY, 7, 4'd0);
        issue(FUNC_QUERY, 8, 4'd0);
        issue(FUNC_READ, 0, 4'd0);
        issue(FUNC_READ, 0, 4'd4);
        issue(FUNC_READ, 0, 4'd5);
        issue(FUNC_ADD, 0, 4'd0);
        issue(FUNC_ADD, -1, 4'd0);
        issue(FUNC_QUERY, WORD_MIN, 4'd0);
        issue(FUNC_QUERY, WORD_MAX, 4'd0);
        issue(FUNC_READ, 0, 4'd15);

        while (beats_sent < ITEMS)
        begin
            if (beats_sent < ITEMS / 3)
                idle_pct = 27;
            else if (beats_sent < 2 * ITEMS / 3)
                idle_pct = 67;
            else
                idle_pct = 0;
            if (!drained && beats_sent >= ITEMS / 2)
            begin
                // hold off until every result is back
                @(negedge clk);
                start = 1'b0;
                while (outstanding != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 40)
                issue(FUNC_ADD, pick_value(), 4'($urandom));
            else if (pick < 70)
                issue(FUNC_QUERY, pick_value(), 4'($urandom));
            else if (pick < 95)
                issue(FUNC_READ, $urandom, 4'($urandom_range(15)));
            else
                issue(FUNC_NOP, $urandom, 4'($urandom));
        end

        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
sv/sisi_pkg.sv
sv/sisi_cell.sv
sv/sorted_int_set_insert_lookup.sv
test/sorted_int_set_insert_lookup_checker.sv
test/sorted_int_set_insert_lookup_test.sv
